>>> src/scpv_pkg.sv
// ----------------------------------------------------------------------------
// scpv_pkg
// Shared types, constants and helpers for the serial checksum / prime checker.
// ----------------------------------------------------------------------------
package scpv_pkg;

	localparam int DIGIT_W     = 4;
	localparam int CAND_W      = 20;
	localparam int WSUM_W      = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// Class of a candidate as decided by the front end
	localparam logic [1:0] CLS_TWO       = 2'd0;  // exactly two: prime
	localparam logic [1:0] CLS_COMPOSITE = 2'd1;  // even or one or zero: not prime
	localparam logic [1:0] CLS_TRIAL     = 2'd2;  // odd, three or above: trial division

	typedef logic [1:0] cls_t;

	typedef struct packed {
		logic [CAND_W-1:0] candidate;
		logic [WSUM_W-1:0] wsum;
		logic              match;
		cls_t              cls;
	} item_t;

	typedef struct packed {
		logic              serial_valid;
		logic              checksum_match;
		logic              candidate_prime;
		logic [CAND_W-1:0] candidate_value;
		logic [WSUM_W-1:0] weighted_sum;
	} res_t;

	function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
		return (d > DIGIT_MAX) ? DIGIT_MAX : d;
	endfunction

endpackage

>>> src/scpv_front.sv
// ----------------------------------------------------------------------------
// scpv_front
// Accepts serial words, builds the candidate and checksum, classifies them.
// ----------------------------------------------------------------------------
module scpv_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [scpv_pkg::IN_TDATA_W-1:0]      in_data,
	output logic                                 push,
	input  logic                                 push_ready,
	output scpv_pkg::item_t                      item
);

	logic                            vld_s1;
	logic [scpv_pkg::DIGIT_W-1:0]    c1_s1, c2_s1, c3_s1, c4_s1, c5_s1, c6_s1;
	logic [scpv_pkg::DIGIT_W-1:0]    ck_hi_s1, ck_lo_s1;
	logic [scpv_pkg::CAND_W-1:0]     cand;
	logic [7:0]                      wraw;
	logic [scpv_pkg::WSUM_W-1:0]     wsum;
	logic [scpv_pkg::WSUM_W-1:0]     check;

	assign in_ready = !vld_s1 || push_ready;
	assign push     = vld_s1 && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Saturate and permute digits on entry
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c1_s1    <= scpv_pkg::sat_digit(in_data[23:20]);
			c2_s1    <= scpv_pkg::sat_digit(in_data[15:12]);
			c3_s1    <= scpv_pkg::sat_digit(in_data[11:8]);
			c4_s1    <= scpv_pkg::sat_digit(in_data[7:4]);
			c5_s1    <= scpv_pkg::sat_digit(in_data[27:24]);
			c6_s1    <= scpv_pkg::sat_digit(in_data[19:16]);
			ck_hi_s1 <= scpv_pkg::sat_digit(in_data[31:28]);
			ck_lo_s1 <= scpv_pkg::sat_digit(in_data[35:32]);
		end
	end

	always_comb begin
		cand = 20'(c1_s1) * 20'd100000 + 20'(c2_s1) * 20'd10000 + 20'(c3_s1) * 20'd1000
		     + 20'(c4_s1) * 20'd100 + 20'(c5_s1) * 20'd10 + 20'(c6_s1);
		wraw = 8'(c1_s1) * 8'd2 + 8'(c2_s1) * 8'd3 + 8'(c3_s1) * 8'd4
		     + 8'(c4_s1) * 8'd4 + 8'(c5_s1) * 8'd3 + 8'(c6_s1) * 8'd2;
		// Sum stays below 200, so one conditional subtract reduces it
		wsum  = (wraw >= 8'd100) ? 7'(wraw - 8'd100) : 7'(wraw);
		check = 7'(ck_hi_s1) * 7'd10 + 7'(ck_lo_s1);

		item.candidate = cand;
		item.wsum      = wsum;
		item.match     = (wsum == check);
		if (cand == 20'd2) begin
			item.cls = scpv_pkg::CLS_TWO;
		end else if (!cand[0] || cand == 20'd1) begin
			item.cls = scpv_pkg::CLS_COMPOSITE;
		end else begin
			item.cls = scpv_pkg::CLS_TRIAL;
		end
	end

endmodule

>>> src/scpv_fifo.sv
// ----------------------------------------------------------------------------
// scpv_fifo
// Short queue between the classifier and the trial divider.
// ----------------------------------------------------------------------------
module scpv_fifo #(
	parameter int DEPTH = scpv_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  scpv_pkg::item_t push_item,
	input  logic            pop,
	output logic            pop_valid,
	output scpv_pkg::item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	scpv_pkg::item_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> src/scpv_back.sv
// ----------------------------------------------------------------------------
// scpv_back
// Trial division over odd divisors, one remainder bit per cycle, and the
// result register.
// ----------------------------------------------------------------------------
module scpv_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  scpv_pkg::item_t item,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_ready,
	output scpv_pkg::res_t  res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam int BIT_W = $clog2(scpv_pkg::CAND_W);

	logic [1:0]                  state_q;
	scpv_pkg::item_t             cur_q;
	logic                        prime_q;
	logic [10:0]                 div_q;
	logic [20:0]                 sq_q;
	logic [9:0]                  rem_q;
	logic [BIT_W-1:0]            bit_q;
	logic                        res_valid_q;
	scpv_pkg::res_t              res_q;
	logic [10:0]                 rem_sh;
	logic [10:0]                 rem_nx;

	assign pop       = (state_q == ST_IDLE) && item_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// One restoring step: shift in the next candidate bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, cur_q.candidate[bit_q]};
		rem_nx = (rem_sh >= div_q) ? rem_sh - div_q : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			// Raise on a new result, drop once the word is taken
			if (state_q == ST_DONE && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= (item.cls == scpv_pkg::CLS_TRIAL) ? ST_CHECK : ST_DONE;
					end
				end
				ST_CHECK: begin
					state_q <= (sq_q > 21'(cur_q.candidate)) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= (rem_nx == '0) ? ST_DONE : ST_CHECK;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q   <= item;
				prime_q <= (item.cls == scpv_pkg::CLS_TWO);
				div_q   <= 11'd3;
				sq_q    <= 21'd9;
			end
			ST_CHECK: begin
				// Past the square root: no divisor found
				prime_q <= 1'b1;
				rem_q   <= '0;
				bit_q   <= BIT_W'(scpv_pkg::CAND_W - 1);
			end
			ST_DIV: begin
				rem_q <= 10'(rem_nx);
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					prime_q <= 1'b0;
					// (i+2)^2 = i^2 + 4i + 4
					sq_q    <= sq_q + {8'd0, div_q, 2'b00} + 21'd4;
					div_q   <= div_q + 11'd2;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_q.serial_valid    <= prime_q && cur_q.match;
					res_q.checksum_match  <= cur_q.match;
					res_q.candidate_prime <= prime_q;
					res_q.candidate_value <= cur_q.candidate;
					res_q.weighted_sum    <= cur_q.wsum;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_q[9:0] || div_q[10])
		else $error("remainder not below divisor");

	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> div_q[0] && div_q >= 11'd3)
		else $error("divisor not odd or below three");

	a_sq_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> sq_q == 21'(div_q) * 21'(div_q))
		else $error("square tracker out of step");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_only_trial_divides: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cur_q.cls == scpv_pkg::CLS_TRIAL)
		else $error("trial division on a pre-classified candidate");

endmodule

>>> src/serial_checksum_prime_validator_top.sv
// ----------------------------------------------------------------------------
// serial_checksum_prime_validator_top
// Checks a nine-digit serial: weighted checksum and primality of a candidate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one word per serial, nine 4-bit digits. Digits
//   above nine are treated as nine. Output channel m_axis_*: one word per
//   serial, in the order taken, with the two test flags, their AND, the
//   assembled six-digit candidate and the weighted sum mod 100.
//   Path: the front registers the word and classifies it, the classified
//   item is pushed into the queue, then the back end takes it. Even
//   candidates, zero, one and two go from the idle state straight to the
//   done state. Odd candidates run trial division over odd divisors up to
//   the square root; each divisor takes one compare in the check state and
//   then one restoring step per candidate bit, 20 bits, in the divide state.
//   The back end works on one candidate at a time and pops the next from
//   the queue only when it is back in its idle state.
//   The queue lets the front take up to three further words while the back
//   end is busy.
//   Reset clears the stage valid, the queue and the result valid flag; no
//   clearing pass is needed. When the receiver stalls, the result word holds
//   in the output register, the back end waits in its done state and the
//   queue, then the input, fill and back-pressure via s_axis_tready.
// ----------------------------------------------------------------------------
module serial_checksum_prime_validator_top #(
	parameter int QUEUE_DEPTH = scpv_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// digit_0 [3:0], digit_1 [7:4], digit_2 [11:8], digit_3 [15:12],
	// digit_4 [19:16], digit_5 [23:20], digit_6 [27:24], digit_7 [31:28],
	// digit_8 [35:32], zero fill [39:36]
	input  logic [scpv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// serial_valid [0], checksum_match [1], candidate_prime [2],
	// candidate_value [22:3], weighted_sum [29:23], zero fill [31:30]
	output logic [scpv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	logic            push, push_ready;
	scpv_pkg::item_t front_item;
	logic            pop, pop_valid;
	scpv_pkg::item_t queue_item;
	scpv_pkg::res_t  res;

	// Front: saturate digits, build candidate and checksum, classify
	scpv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push       (push),
		.push_ready (push_ready),
		.item       (front_item)
	);

	// Queue: decouple the classifier from the divider
	scpv_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (front_item),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (queue_item)
	);

	// Back: trial division and result register
	scpv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item       (queue_item),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	// Pack the result word, first field in the lowest bit
	assign m_axis_tdata = {2'b00, res.weighted_sum, res.candidate_value,
	                       res.candidate_prime, res.checksum_match, res.serial_valid};

endmodule
